/* sv/pir_pkg.sv */
// package for the packet impairment reorder window block
// holds field widths, register indexes, action codes and shared types
// no dependencies
package pir_pkg;

  localparam int DEF_WINDOW_DEPTH = 32;
  localparam int DEF_HANDLE_WIDTH = 16;

  localparam int ACTION_W    = 2;
  localparam int HANDLE_W    = 16;
  localparam int DRAW_W      = 10;
  localparam int PICK_W      = 16;
  localparam int PERMILLE_W  = 10;
  localparam int WIN_W       = 6;
  localparam int HOLD_W      = 16;
  localparam int COUNT_W     = 6;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DROP_PERMILLE  = 2'd0,
    REG_DUP_PERMILLE   = 2'd1,
    REG_WINDOW_SIZE    = 2'd2,
    REG_MAX_HOLD_MS    = 2'd3
  } reg_index_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INBOUND  = 2'd0,
    ACT_OUTBOUND = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_FLUSH    = 2'd3
  } action_t;

  localparam logic KIND_PACKET  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // buffer commands, push and pop never in the same cycle
  typedef struct packed {
    logic push;
    logic pop;
  } buf_cmd_t;

  function automatic logic roll(input logic [PERMILLE_W-1:0] permille,
                                input logic [DRAW_W-1:0] draw);
    roll = (permille != '0) && (draw < permille);
  endfunction

endpackage

/* sv/pir_mul.sv */
// shift-add multiplier, one multiplier bit per cycle
// forms pick * fill for the release index; uses pir_pkg
module pir_mul #(
  parameter int FILL_W = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [pir_pkg::PICK_W-1:0]          pick,
  input  logic [FILL_W-1:0]                   fill,
  output logic                                done,
  output logic [FILL_W-1:0]                   product_hi
);
  import pir_pkg::*;

  localparam int PROD_W = PICK_W + FILL_W;
  localparam int CNT_W  = (FILL_W > 1) ? $clog2(FILL_W) : 1;

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] addend;
  logic [FILL_W-1:0] mult;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(FILL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      addend <= PROD_W'(pick);
      mult   <= fill;
    end else if (busy) begin
      if (mult[0]) begin
        acc <= acc + addend;
      end
      addend <= addend << 1;
      mult   <= mult >> 1;
    end
  end

  // pick is below 2^16, so the high part is below fill whenever fill is nonzero
  assign product_hi = acc[PICK_W +: FILL_W];

endmodule

/* sv/pir_buf.sv */
// reorder buffer: append at the tail, remove at any index with the gap
// closed in the same cycle; uses pir_pkg
module pir_buf #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 16,
  parameter int IDX_W  = 5,
  parameter int FILL_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  pir_pkg::buf_cmd_t cmd,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  idx,
  output logic [DATA_W-1:0] rd_data,
  output logic [FILL_W-1:0] fill,
  output logic              full
);
  import pir_pkg::*;

  logic [DATA_W-1:0] entries [DEPTH];

  assign full    = (fill == FILL_W'(DEPTH));
  assign rd_data = entries[idx];

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDX_W'(i) >= idx) begin
          entries[i] <= entries[i+1];
        end
      end
    end
    if (cmd.push && !full) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (fill == FILL_W'(i)) begin
          entries[i] <= wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.push && !full) begin
      fill <= fill + FILL_W'(1);
    end else if (cmd.pop) begin
      fill <= fill - FILL_W'(1);
    end
  end

endmodule

/* sv/packet_impairment_reorder_window_top.sv */
// packet impairment top: drop, duplicate and random reorder window
// inbound packet with window: append (twice with a duplicate) and check, and if due
// multiply (shift-add, one bit per cycle, FILL_W = clog2(WINDOW_DEPTH+1)) and release;
// query and direct copies are loaded into the output register
// throughput: one item at a time; flush sends one entry per cycle unless output stalls
// reset: synchronous, clears fill, idle count and registers, hold limit to 100
// depends on pir_pkg, pir_mul, pir_buf
module packet_impairment_reorder_window_top #(
  parameter int WINDOW_DEPTH = pir_pkg::DEF_WINDOW_DEPTH,
  parameter int HANDLE_WIDTH = pir_pkg::DEF_HANDLE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pir_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pir_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pir_pkg::ACTION_W-1:0]      action,
  input  logic [pir_pkg::HANDLE_W-1:0]      packet_handle,
  input  logic [pir_pkg::DRAW_W-1:0]        drop_draw,
  input  logic [pir_pkg::DRAW_W-1:0]        dup_draw,
  input  logic [pir_pkg::PICK_W-1:0]        pick_draw,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pir_pkg::HANDLE_W-1:0]      out_handle,
  output logic                              kind,
  output logic                              outbound_drop,
  output logic [pir_pkg::COUNT_W-1:0]       buffer_count,
  output logic                              overflowed,
  output logic                              last
);
  import pir_pkg::*;

  localparam int IDX_W   = $clog2(WINDOW_DEPTH);
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int STORE_W = (HANDLE_WIDTH < HANDLE_W) ? HANDLE_WIDTH : HANDLE_W;
  localparam int CMP_W   = (FILL_W > WIN_W) ? FILL_W : WIN_W;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_APPEND  = 8'b0000_0010,
    S_CHECK   = 8'b0000_0100,
    S_MUL     = 8'b0000_1000,
    S_RELEASE = 8'b0001_0000,
    S_FLUSH   = 8'b0010_0000,
    S_DIRECT  = 8'b0100_0000,
    S_VERDICT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [PERMILLE_W-1:0] drop_permille;
  logic [PERMILLE_W-1:0] duplicate_permille;
  logic [WIN_W-1:0]      reorder_window_size;
  logic [HOLD_W-1:0]     reorder_max_hold_ms;
  logic [HOLD_W-1:0]     idle_ms;

  logic [STORE_W-1:0]    handle_q;
  logic [PICK_W-1:0]     pick_q;
  logic                  verdict_q;
  logic                  dup_pending;
  logic                  ovf_q;
  logic [IDX_W-1:0]      idx_q;

  logic                  accept;
  logic                  out_free;
  logic                  load;
  logic                  mul_start;
  logic                  mul_done;
  logic [FILL_W-1:0]     mul_hi;
  buf_cmd_t              cmd;
  logic [STORE_W-1:0]    rd_data;
  logic [FILL_W-1:0]     fill;
  logic                  full;
  logic                  release_due;
  logic                  flush_due;

  logic [HANDLE_W-1:0]   res_handle;
  logic                  res_kind;
  logic                  res_verdict;
  logic [COUNT_W-1:0]    res_count;
  logic                  res_ovf;
  logic                  res_last;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // release once fill reaches min(window, depth)
  assign release_due = (fill != '0) &&
                       ((CMP_W'(fill) >= CMP_W'(reorder_window_size)) ||
                        (fill == FILL_W'(WINDOW_DEPTH)));
  assign flush_due   = (fill != '0) && (reorder_window_size != '0) &&
                       (idle_ms >= reorder_max_hold_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_permille       <= '0;
      duplicate_permille  <= '0;
      reorder_window_size <= '0;
      reorder_max_hold_ms <= HOLD_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_DROP_PERMILLE: drop_permille       <= cfg_data[PERMILLE_W-1:0];
        REG_DUP_PERMILLE:  duplicate_permille  <= cfg_data[PERMILLE_W-1:0];
        REG_WINDOW_SIZE:   reorder_window_size <= cfg_data[WIN_W-1:0];
        REG_MAX_HOLD_MS:   reorder_max_hold_ms <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    mul_start   = 1'b0;
    load        = 1'b0;
    res_handle  = HANDLE_W'(handle_q);
    res_kind    = KIND_PACKET;
    res_verdict = 1'b0;
    res_count   = COUNT_W'(fill);
    res_ovf     = 1'b0;
    res_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(action))
            ACT_INBOUND: begin
              if (!roll(drop_permille, drop_draw)) begin
                state_next = (reorder_window_size == '0) ? S_DIRECT : S_APPEND;
              end
            end
            ACT_OUTBOUND: state_next = S_VERDICT;
            ACT_TICK:     state_next = S_IDLE;
            ACT_FLUSH: begin
              if (flush_due) begin
                state_next = S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_APPEND: begin
        cmd.push = 1'b1;
        if (!dup_pending) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (release_due) begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = S_RELEASE;
        end
      end
      S_RELEASE: begin
        res_handle = HANDLE_W'(rd_data);
        res_count  = COUNT_W'(fill - FILL_W'(1));
        res_ovf    = ovf_q;
        if (out_free) begin
          load       = 1'b1;
          cmd.pop    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        // drain from the head so the gap closing keeps the oldest at index zero
        res_handle = HANDLE_W'(rd_data);
        res_count  = COUNT_W'(fill - FILL_W'(1));
        res_last   = (fill == FILL_W'(1));
        if (out_free) begin
          load    = 1'b1;
          cmd.pop = 1'b1;
          if (fill == FILL_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_DIRECT: begin
        res_last = !dup_pending;
        if (out_free) begin
          load = 1'b1;
          if (!dup_pending) begin
            state_next = S_IDLE;
          end
        end
      end
      S_VERDICT: begin
        res_handle  = '0;
        res_kind    = KIND_VERDICT;
        res_verdict = verdict_q;
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idle_ms     <= '0;
      dup_pending <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && action_t'(action) == ACT_INBOUND) begin
        dup_pending <= roll(duplicate_permille, dup_draw);
        ovf_q       <= 1'b0;
        if (!roll(drop_permille, drop_draw) && reorder_window_size != '0) begin
          idle_ms <= '0;
        end
      end else if (accept && action_t'(action) == ACT_TICK) begin
        if (idle_ms != '1) begin
          idle_ms <= idle_ms + HOLD_W'(1);
        end
      end
      if (state == S_APPEND) begin
        dup_pending <= 1'b0;
        if (full) begin
          ovf_q <= 1'b1;
        end
      end
      if (state == S_DIRECT && out_free) begin
        dup_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      handle_q  <= STORE_W'(packet_handle);
      pick_q    <= pick_draw;
      verdict_q <= roll(drop_permille, drop_draw);
      idx_q     <= '0;
    end else if (state == S_MUL && mul_done) begin
      idx_q <= IDX_W'(mul_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_handle    <= res_handle;
      kind          <= res_kind;
      outbound_drop <= res_verdict;
      buffer_count  <= res_count;
      overflowed    <= res_ovf;
      last          <= res_last;
    end
  end

  pir_mul #(
    .FILL_W (FILL_W)
  ) u_mul (
    .clk        (clk),
    .rst        (rst),
    .start      (mul_start),
    .pick       (pick_q),
    .fill       (fill),
    .done       (mul_done),
    .product_hi (mul_hi)
  );

  pir_buf #(
    .DEPTH  (WINDOW_DEPTH),
    .DATA_W (STORE_W),
    .IDX_W  (IDX_W),
    .FILL_W (FILL_W)
  ) u_buf (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .wr_data (handle_q),
    .idx     (idx_q),
    .rd_data (rd_data),
    .fill    (fill),
    .full    (full)
  );

endmodule
